@@ design/gsr_pkg.sv @@
// shared types, constants and helper functions of the autoranging unit
`timescale 1ns / 1ps
`default_nettype none

package gsr_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned RANGE_W  = 2;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PINS_SWAPPED = 2'd2;

    localparam logic [MODE_W-1:0]   MODE_AUTO     = 3'd4;
    localparam logic [MODE_W-1:0]   MODE_FIXED_HI = 3'd3;
    localparam logic [PERIOD_W-1:0] PeriodReset   = 16'd320;

    // range codes
    localparam logic [RANGE_W-1:0] RANGE_40K  = 2'd0;
    localparam logic [RANGE_W-1:0] RANGE_287K = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_1M   = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_3M3  = 2'd3;

    // hysteresis thresholds
    localparam logic [SAMPLE_W-1:0] TH_40K_DOWN  = 12'd1120;
    localparam logic [SAMPLE_W-1:0] TH_287K_UP   = 12'd3960;
    localparam logic [SAMPLE_W-1:0] TH_287K_DOWN = 12'd1490;
    localparam logic [SAMPLE_W-1:0] TH_1M_UP     = 12'd3700;
    localparam logic [SAMPLE_W-1:0] TH_1M_DOWN   = 12'd1630;
    localparam logic [SAMPLE_W-1:0] TH_3M3_UP    = 12'd3930;

    typedef struct packed {
        logic [RANGE_W-1:0]  active;
        logic [RANGE_W-1:0]  prev_seen;
        logic [RANGE_W-1:0]  held;
        logic [SAMPLE_W-1:0] hold_rem;
        logic [SAMPLE_W-1:0] last_out;
    } gsr_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [RANGE_W-1:0]  code;
        logic                a0;
        logic                a1;
        logic                settling;
    } gsr_result_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [SAMPLE_W-1:0] quotient;
    } gsr_div_status_t;

    // hysteresis decision for the next resistor
    function automatic logic [RANGE_W-1:0] next_range(
        input logic [RANGE_W-1:0]  r,
        input logic [SAMPLE_W-1:0] v
    );
        logic [RANGE_W-1:0] n;
        n = r;
        unique case (r)
            RANGE_40K:
            begin
                if (v < TH_40K_DOWN) n = RANGE_287K;
            end
            RANGE_287K:
            begin
                if (v < TH_287K_DOWN)    n = RANGE_1M;
                else if (v > TH_287K_UP) n = RANGE_40K;
            end
            RANGE_1M:
            begin
                if (v < TH_1M_DOWN)    n = RANGE_3M3;
                else if (v > TH_1M_UP) n = RANGE_287K;
            end
            default:
            begin
                if (v > TH_3M3_UP) n = RANGE_1M;
            end
        endcase
        return n;
    endfunction

    // mux address pins {a1, a0} for a range code
    function automatic logic [1:0] select_pins(
        input logic [RANGE_W-1:0] r,
        input logic               swapped
    );
        logic [1:0] p;
        unique case (r)
            RANGE_40K:  p = 2'b00;
            RANGE_287K: p = swapped ? 2'b10 : 2'b01;
            RANGE_1M:   p = swapped ? 2'b01 : 2'b10;
            default:    p = 2'b11;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ design/gsr_autorange_settling_hold_unit.sv @@
// top level of the skin-conductance autoranging unit with settling hold
`timescale 1ns / 1ps
`default_nettype none

// Takes one 12-bit converter word per cycle and returns one word per input
// through an input register, then a result register. In automatic
// mode (range_mode 4) the unit picks one of four feedback resistors with
// fixed hysteresis thresholds; after a resistor change it repeats the last
// output for floor(SETTLE_TICKS / sample_period_ticks) words with the old
// range code and settling set. The first STARTUP_IGNORE words after reset or
// any register write are held as well. Any register write restarts the
// state. Writing sample_period_ticks starts a bit-serial divider that runs
// one quotient bit per cycle; in_stall stays high while it runs.
// Otherwise the sustained rate is one word per cycle, limited only by
// out_stall.

module gsr_autorange_settling_hold_unit #(
    parameter int unsigned SETTLE_TICKS   = 2621,
    parameter int unsigned STARTUP_IGNORE = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [gsr_pkg::SAMPLE_W-1:0]   adc_sample,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [gsr_pkg::SAMPLE_W-1:0]        out_sample,
    output logic [gsr_pkg::RANGE_W-1:0]         range_code,
    output logic                                select_pin_a0,
    output logic                                select_pin_a1,
    output logic                                settling,
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [gsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gsr_pkg::PERIOD_W-1:0]   cfg_data
);

    localparam logic [gsr_pkg::SAMPLE_W-1:0] HOLD_RESET =
        gsr_pkg::SAMPLE_W'(SETTLE_TICKS / gsr_pkg::PeriodReset);
    localparam logic [gsr_pkg::SAMPLE_W-1:0] STARTUP_HOLD =
        gsr_pkg::SAMPLE_W'(STARTUP_IGNORE);

    // configuration registers
    logic [gsr_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic                         swap_reg, swap_next;
    logic [gsr_pkg::SAMPLE_W-1:0] hold_len_reg, hold_len_next;

    // ranging state
    gsr_pkg::gsr_state_t          state_reg, state_next, state_upd, state_init;

    // input stage
    logic                         s1_valid_reg, s1_valid_next;
    logic [gsr_pkg::SAMPLE_W-1:0] s1_sample_reg, s1_sample_next;

    // result stage
    logic                         out_valid_reg, out_valid_next;
    gsr_pkg::gsr_result_t         out_reg, out_next, step_result;

    // config decode
    logic                         cfg_hit;
    logic                         wr_mode;
    logic                         wr_period;
    logic                         wr_swap;

    // handshake
    logic                         in_accept;
    logic                         s1_move;
    logic                         auto_mode;

    gsr_pkg::gsr_div_status_t     div_status;

    always_comb
    begin
        wr_mode   = 1'b0;
        wr_period = 1'b0;
        wr_swap   = 1'b0;
        unique case (cfg_index)
            gsr_pkg::CFG_RANGE_MODE:    wr_mode   = cfg_we;
            gsr_pkg::CFG_SAMPLE_PERIOD: wr_period = cfg_we;
            gsr_pkg::CFG_PINS_SWAPPED:  wr_swap   = cfg_we;
            default:                    ;   // writes past the list are dropped
        endcase
        cfg_hit = wr_mode || wr_period || wr_swap;
    end

    // hold length comes from the divider after a period write
    gsr_div #(
        .DIVIDEND (SETTLE_TICKS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (wr_period),
        .divisor (cfg_data),
        .status  (div_status)
    );

    assign auto_mode = (mode_reg == gsr_pkg::MODE_AUTO);

    gsr_step u_step (
        .auto_mode   (auto_mode),
        .swapped     (swap_reg),
        .hold_length (hold_len_reg),
        .sample      (s1_sample_reg),
        .state       (state_reg),
        .state_upd   (state_upd),
        .result      (step_result)
    );

    // pipeline handshake: the result register frees as it is taken
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = div_status.busy || (s1_valid_reg && !s1_move);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        mode_next     = wr_mode ? cfg_data[gsr_pkg::MODE_W-1:0] : mode_reg;
        swap_next     = wr_swap ? cfg_data[0] : swap_reg;
        hold_len_next = div_status.done ? div_status.quotient : hold_len_reg;

        // restart values follow the mode being written
        state_init.active    = (mode_next <= gsr_pkg::MODE_FIXED_HI) ?
                               mode_next[gsr_pkg::RANGE_W-1:0] : gsr_pkg::RANGE_40K;
        state_init.prev_seen = state_init.active;
        state_init.held      = gsr_pkg::RANGE_40K;
        state_init.hold_rem  = STARTUP_HOLD;
        state_init.last_out  = '0;

        if (cfg_hit)
            state_next = state_init;
        else if (s1_move)
            state_next = state_upd;
        else
            state_next = state_reg;

        s1_valid_next  = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        s1_sample_next = in_accept ? adc_sample : s1_sample_reg;

        out_valid_next = s1_move ? 1'b1 :
                         ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);
        out_next       = s1_move ? step_result : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= gsr_pkg::MODE_AUTO;
            swap_reg            <= 1'b0;
            hold_len_reg        <= HOLD_RESET;
            state_reg.active    <= gsr_pkg::RANGE_40K;
            state_reg.prev_seen <= gsr_pkg::RANGE_40K;
            state_reg.held      <= gsr_pkg::RANGE_40K;
            state_reg.hold_rem  <= STARTUP_HOLD;
            state_reg.last_out  <= '0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            swap_reg      <= swap_next;
            hold_len_reg  <= hold_len_next;
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_sample_reg <= s1_sample_next;
        out_reg       <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_sample    = out_reg.sample;
    assign range_code    = out_reg.code;
    assign select_pin_a0 = out_reg.a0;
    assign select_pin_a1 = out_reg.a1;
    assign settling      = out_reg.settling;

    // no word enters while the hold length is being worked out
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> in_stall)
        else $error("word accepted during hold length division");

    // a period write always starts the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_period |=> div_status.busy)
        else $error("period write did not start the divider");

    // a held word in the input stage waits for the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> s1_valid_reg)
        else $error("input stage word lost while result stalled");

    // only automatic ranging ever repeats a held word
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && step_result.settling) |-> auto_mode)
        else $error("settling word produced in fixed mode");

endmodule

`default_nettype wire

@@ design/gsr_div.sv @@
// bit-serial restoring divider for the hold length
`timescale 1ns / 1ps
`default_nettype none

module gsr_div #(
    parameter int unsigned DIVIDEND = 2621
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [gsr_pkg::PERIOD_W-1:0]  divisor,
    output gsr_pkg::gsr_div_status_t           status
);

    localparam int unsigned QW = gsr_pkg::SAMPLE_W;
    localparam int unsigned CW = $clog2(QW);
    localparam logic [CW-1:0] LAST_STEP = CW'(QW - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [QW-1:0]                 rem_reg, rem_next;
    logic [QW-1:0]                 quo_reg, quo_next;   // dividend shifts out, quotient in
    logic [gsr_pkg::PERIOD_W-1:0]  dvs_reg, dvs_next;
    logic [QW:0]                   trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign fits  = {{(gsr_pkg::PERIOD_W-QW-1){1'b0}}, trial} >= dvs_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = QW'(DIVIDEND);
            // zero period counts as one
            dvs_next  = (divisor == '0) ? gsr_pkg::PERIOD_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? QW'(trial - (QW+1)'(dvs_reg)) : trial[QW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

`default_nettype wire

@@ design/gsr_step.sv @@
// one-sample autoranging decision and settling hold update
`timescale 1ns / 1ps
`default_nettype none

module gsr_step (
    input  wire logic                          auto_mode,
    input  wire logic                          swapped,
    input  wire logic [gsr_pkg::SAMPLE_W-1:0]  hold_length,
    input  wire logic [gsr_pkg::SAMPLE_W-1:0]  sample,
    input  wire gsr_pkg::gsr_state_t           state,
    output gsr_pkg::gsr_state_t                state_upd,
    output gsr_pkg::gsr_result_t               result
);

    logic [gsr_pkg::SAMPLE_W-1:0] rem;
    logic [gsr_pkg::RANGE_W-1:0]  held;
    logic [1:0]                   pins;

    always_comb
    begin
        state_upd       = state;
        rem             = state.hold_rem;
        held            = state.held;
        result.sample   = sample;
        result.code     = state.active;
        result.settling = 1'b0;
        if (auto_mode)
        begin
            if (state.active != state.prev_seen)
            begin
                if ((state.hold_rem != '0) && (state.held == state.active))
                begin
                    rem = '0;   // back to the held range, drop the hold
                end
                else
                begin
                    rem  = hold_length;
                    held = state.prev_seen;
                end
            end
            state_upd.prev_seen = state.active;
            state_upd.held      = held;
            if (rem != '0)
            begin
                state_upd.hold_rem = rem - gsr_pkg::SAMPLE_W'(1);
                result.sample      = state.last_out;
                result.code        = held;
                result.settling    = 1'b1;
            end
            else
            begin
                state_upd.hold_rem = rem;
                state_upd.active   = gsr_pkg::next_range(state.active, sample);
            end
        end
        state_upd.last_out = result.sample;
        pins          = gsr_pkg::select_pins(state_upd.active, swapped);
        result.a0     = pins[0];
        result.a1     = pins[1];
    end

endmodule

`default_nettype wire

@@ bench/gsr_autorange_settling_hold_unit_tb.sv @@
// testbench of the skin-conductance autoranging unit with settling hold
`timescale 1ns / 1ps

module gsr_autorange_settling_hold_unit_tb;

    // hysteresis limits, kept apart from the package so a wrong package constant shows up
    localparam logic [11:0] LIM_40K_LOW   = 12'd1120;
    localparam logic [11:0] LIM_287K_LOW  = 12'd1490;
    localparam logic [11:0] LIM_287K_HIGH = 12'd3960;
    localparam logic [11:0] LIM_1M_LOW    = 12'd1630;
    localparam logic [11:0] LIM_1M_HIGH   = 12'd3700;
    localparam logic [11:0] LIM_3M3_HIGH  = 12'd3930;
    localparam int unsigned SETTLE_LEN    = 2621;
    localparam int unsigned STARTUP_LEN   = 6;

    // cycles with no word moving on either side before the run is declared hung
    localparam int unsigned STALL_LIMIT   = 2000;
    // long receiver hold-off that fills the unit and pushes back on the sender
    localparam int unsigned HOLD_OFF_LEN  = 400;

    // tracks the range decision and settling hold, and keeps the words still owed
    class range_hold_model;
        logic [gsr_pkg::MODE_W-1:0]   mode;
        logic [gsr_pkg::PERIOD_W-1:0] period;
        logic                         swap;
        logic [1:0]                   active;
        logic [1:0]                   prev_seen;
        logic [1:0]                   held_r;
        logic [11:0]                  hold_rem;
        logic [11:0]                  last_out;
        logic [11:0]                  hold_len;
        gsr_pkg::gsr_result_t         expected_words[$];
        int                           errors;

        function new();
            mode   = gsr_pkg::MODE_AUTO;
            period = gsr_pkg::PeriodReset;
            swap   = 1'b0;
            errors = 0;
            restart();
        endfunction

        // any register write starts over from here
        function void restart();
            int unsigned p;
            p         = (period == 0) ? 1 : period;
            active    = (mode <= 3) ? mode[1:0] : gsr_pkg::RANGE_40K;
            prev_seen = active;
            held_r    = gsr_pkg::RANGE_40K;
            hold_rem  = 12'(STARTUP_LEN);
            last_out  = '0;
            hold_len  = 12'(SETTLE_LEN / p);
        endfunction

        function void write_reg(logic [gsr_pkg::CFG_IDX_W-1:0] idx,
                                logic [gsr_pkg::PERIOD_W-1:0] data);
            case (idx)
                gsr_pkg::CFG_RANGE_MODE:    mode = data[gsr_pkg::MODE_W-1:0];
                gsr_pkg::CFG_SAMPLE_PERIOD: period = data;
                gsr_pkg::CFG_PINS_SWAPPED:  swap = data[0];
                default:                    return;
            endcase
            restart();
        endfunction

        function logic [1:0] step_range(logic [1:0] r, logic [11:0] v);
            case (r)
                gsr_pkg::RANGE_40K:
                    return (v < LIM_40K_LOW) ? gsr_pkg::RANGE_287K : gsr_pkg::RANGE_40K;
                gsr_pkg::RANGE_287K:
                begin
                    if (v < LIM_287K_LOW)  return gsr_pkg::RANGE_1M;
                    if (v > LIM_287K_HIGH) return gsr_pkg::RANGE_40K;
                    return gsr_pkg::RANGE_287K;
                end
                gsr_pkg::RANGE_1M:
                begin
                    if (v < LIM_1M_LOW)  return gsr_pkg::RANGE_3M3;
                    if (v > LIM_1M_HIGH) return gsr_pkg::RANGE_287K;
                    return gsr_pkg::RANGE_1M;
                end
                default:
                    return (v > LIM_3M3_HIGH) ? gsr_pkg::RANGE_1M : gsr_pkg::RANGE_3M3;
            endcase
        endfunction

        // {a1, a0}; the two middle codes trade patterns when swapped
        function logic [1:0] pins_for(logic [1:0] r);
            case (r)
                gsr_pkg::RANGE_40K:  return 2'b00;
                gsr_pkg::RANGE_287K: return {swap, ~swap};
                gsr_pkg::RANGE_1M:   return {~swap, swap};
                default:             return 2'b11;
            endcase
        endfunction

        function void note_sample(logic [11:0] v);
            gsr_pkg::gsr_result_t w;
            logic [1:0]           r;
            w.sample   = v;
            w.code     = active;
            w.settling = 1'b0;
            if (mode == gsr_pkg::MODE_AUTO)
            begin
                r = active;
                if (r != prev_seen)
                begin
                    if (hold_rem != 0 && held_r == r)
                        hold_rem = '0;
                    else
                    begin
                        hold_rem = hold_len;
                        held_r   = prev_seen;
                    end
                end
                prev_seen = r;
                if (hold_rem != 0)
                begin
                    hold_rem   = hold_rem - 1'b1;
                    w.code     = held_r;
                    w.sample   = last_out;
                    w.settling = 1'b1;
                end
                else
                    active = step_range(r, v);
            end
            last_out = w.sample;
            {w.a1, w.a0} = pins_for(active);
            expected_words.push_back(w);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_word(gsr_pkg::gsr_result_t got);
            gsr_pkg::gsr_result_t w;
            if (expected_words.size() == 0)
            begin
                $error("output word with nothing pending: sample %0d code %0d",
                       got.sample, got.code);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            compare_field("out_sample", w.sample, got.sample);
            compare_field("range_code", w.code, got.code);
            compare_field("select_pin_a0", w.a0, got.a0);
            compare_field("select_pin_a1", w.a1, got.a1);
            compare_field("settling", w.settling, got.settling);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [gsr_pkg::SAMPLE_W-1:0]  adc_sample;
    logic                          out_valid;
    logic                          out_stall;
    logic [gsr_pkg::SAMPLE_W-1:0]  out_sample;
    logic [gsr_pkg::RANGE_W-1:0]   range_code;
    logic                          select_pin_a0;
    logic                          select_pin_a1;
    logic                          settling;
    logic                          cfg_we;
    logic [gsr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gsr_pkg::PERIOD_W-1:0]  cfg_data;

    range_hold_model hold_model;

    // per-phase knobs shared by the driving processes
    bit sender_gaps;
    bit receiver_gaps;
    bit hold_off_now;
    int unsigned idle_cycles;

    gsr_autorange_settling_hold_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .adc_sample    (adc_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_sample    (out_sample),
        .range_code    (range_code),
        .select_pin_a0 (select_pin_a0),
        .select_pin_a1 (select_pin_a1),
        .settling      (settling),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // samples spread toward the hysteresis limits so the range walks up and down
    function automatic logic [11:0] pick_sample();
        int unsigned k;
        int          lim;
        k = $urandom_range(0, 9);
        case (k)
            0, 1:    return 12'($urandom_range(0, LIM_40K_LOW - 1));
            2, 3:    return 12'($urandom_range(LIM_287K_HIGH + 1, 4095));
            4, 5:
            begin
                case ($urandom_range(0, 5))
                    0:       lim = LIM_40K_LOW;
                    1:       lim = LIM_287K_LOW;
                    2:       lim = LIM_287K_HIGH;
                    3:       lim = LIM_1M_LOW;
                    4:       lim = LIM_1M_HIGH;
                    default: lim = LIM_3M3_HIGH;
                endcase
                return 12'(lim + int'($urandom_range(0, 8)) - 4);
            end
            6:       return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // one word into the unit; may open with a burst of idle cycles
    task automatic push_word(input logic [11:0] v);
        @(negedge clk);
        if (sender_gaps && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= v;
        do
            @(posedge clk);
        while (in_stall);
        hold_model.note_sample(v);
    endtask

    // drop valid and let every owed word drain out before touching registers
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (hold_model.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gsr_pkg::PERIOD_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        hold_model.write_reg(idx, data);
    endtask

    // period goes last: its write kicks off the hold-length divider
    task automatic set_config(input logic [2:0] mode, input logic [15:0] period, input bit swap);
        write_reg(gsr_pkg::CFG_RANGE_MODE, {13'd0, mode});
        write_reg(gsr_pkg::CFG_PINS_SWAPPED, {15'd0, swap});
        write_reg(gsr_pkg::CFG_SAMPLE_PERIOD, period);
    endtask

    task automatic run_phase(input logic [2:0] mode, input logic [15:0] period, input bit swap,
                             input int unsigned count);
        drain();
        set_config(mode, period, swap);
        repeat (count) push_word(pick_sample());
    endtask

    // receiver side: random stall bursts, plus the one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_now)
            begin
                hold_off_now = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // every accepted output word goes to the scoreboard
    always @(posedge clk)
    begin
        gsr_pkg::gsr_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.sample   = out_sample;
            got.code     = range_code;
            got.a0       = select_pin_a0;
            got.a1       = select_pin_a1;
            got.settling = settling;
            hold_model.check_word(got);
        end
    end

    // hang detector: any word moving on either side resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("gsr_autorange_settling_hold_unit_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned random_words;
        int unsigned n;
        logic [2:0]  mode;
        logic [15:0] period;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        adc_sample    = '0;
        cfg_we        = 1'b0;
        cfg_index     = gsr_pkg::CFG_RANGE_MODE;
        cfg_data      = '0;
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        hold_off_now  = 1'b0;
        idle_cycles   = 0;
        hold_model    = new();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: startup hold swallows extremes, then 1119 switches the range to 287k
        push_word(12'd0);
        push_word(12'd4095);
        push_word(12'd2730);
        push_word(12'd1365);
        push_word(12'd1);
        push_word(12'd4094);
        push_word(12'd1119);

        // one-word hold; step across each lower limit and sit on the upper ones
        drain();
        write_reg(gsr_pkg::CFG_SAMPLE_PERIOD, 16'd2621);
        repeat (STARTUP_LEN) push_word(12'd2048);
        push_word(LIM_40K_LOW);
        push_word(LIM_40K_LOW - 12'd1);
        push_word(12'd2000);
        push_word(LIM_287K_LOW);
        push_word(LIM_287K_HIGH);
        push_word(LIM_287K_LOW - 12'd1);
        push_word(12'd2000);
        push_word(LIM_1M_HIGH);
        push_word(LIM_1M_LOW);
        push_word(LIM_1M_LOW - 12'd1);
        push_word(12'd2000);
        push_word(LIM_3M3_HIGH);

        // fixed settings, the odd modes above 4, and the period extremes
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        run_phase(gsr_pkg::MODE_AUTO, 16'd1000, 1'b1, 120);
        run_phase(3'd0, 16'd320, 1'b0, 30);
        run_phase(3'd1, 16'd320, 1'b1, 30);
        run_phase(3'd2, 16'd320, 1'b0, 30);
        run_phase(3'd3, 16'd320, 1'b1, 30);
        run_phase(3'd5, 16'd320, 1'b0, 15);
        run_phase(3'd6, 16'd320, 1'b1, 15);
        run_phase(3'd7, 16'd65535, 1'b0, 15);
        // zero period counts as one tick: after a range change every word stays held
        run_phase(gsr_pkg::MODE_AUTO, 16'd0, 1'b0, 40);

        // backpressure: sender runs flat out into a long receiver hold-off
        drain();
        set_config(gsr_pkg::MODE_AUTO, 16'd65535, 1'b1);
        sender_gaps  = 1'b0;
        hold_off_now = 1'b1;
        repeat (150) push_word(pick_sample());
        sender_gaps = 1'b1;

        run_phase(gsr_pkg::MODE_AUTO, 16'd1, 1'b1, 30);
        random_words = 505;

        while (random_words < 990)
        begin
            sender_gaps   = 1'($urandom_range(0, 1));
            receiver_gaps = 1'($urandom_range(0, 1));
            mode   = ($urandom_range(0, 9) < 7) ? gsr_pkg::MODE_AUTO
                                                : 3'($urandom_range(0, 7));
            period = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(100, 2621));
            n = $urandom_range(40, 100);
            run_phase(mode, period, 1'($urandom_range(0, 1)), n);
            random_words += n;
        end

        // closing stretch at full rate on both sides
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        run_phase(gsr_pkg::MODE_AUTO, 16'd2621, 1'b0, 60);

        drain();
        repeat (10) @(posedge clk);
        if (hold_model.errors == 0 && hold_model.pending() == 0)
            $display("gsr_autorange_settling_hold_unit_tb: done, clean");
        else
            $display("gsr_autorange_settling_hold_unit_tb: done, errors");
        $finish;
    end

endmodule
